[design/ipv_pkg.sv]
// Shared types and codes for the IPv4/IPv6 address text validator.
// Used by ipv_front, ipv_queue, ipv_back and ip_address_text_validator.
package ipv_pkg;

  // Depth of the queue between front and back.
  localparam int QueueDepthDefault = 2;

  // Verdict codes.
  localparam logic [1:0] VerdictNeither = 2'd0;
  localparam logic [1:0] VerdictIpv4    = 2'd1;
  localparam logic [1:0] VerdictIpv6    = 2'd2;

  // Classified character, as queued between front and back.
  typedef struct packed {
    logic       is_dot;
    logic       is_colon;
    logic       is_dec;
    logic       is_hex;
    logic       is_zero;
    logic [3:0] digit;
    logic       last;
  } ipv_class_t;

endpackage

[design/ipv_front.sv]
// Front end of the address validator: classifies one text character.
// Depends on ipv_pkg for the class struct.
module ipv_front (
  input  logic [7:0]          char_code,
  input  logic                last_char,
  output ipv_pkg::ipv_class_t cls
);

  logic is_dec;
  logic is_lower;
  logic is_upper;
  logic [7:0] offset;

  // Sort the character into separator, decimal or hex digit
  always_comb begin
    is_dec   = (char_code >= 8'h30) && (char_code <= 8'h39);
    is_lower = (char_code >= 8'h61) && (char_code <= 8'h66);
    is_upper = (char_code >= 8'h41) && (char_code <= 8'h46);
    offset   = char_code - 8'h30;

    cls.is_dot   = (char_code == 8'h2E);
    cls.is_colon = (char_code == 8'h3A);
    cls.is_dec   = is_dec;
    cls.is_hex   = is_dec | is_lower | is_upper;
    cls.is_zero  = (char_code == 8'h30);
    cls.digit    = offset[3:0];
    cls.last     = last_char;
  end

endmodule

[design/ipv_queue.sv]
// Short FIFO of classified characters between front and back.
// Depends on ipv_pkg for the class struct.
module ipv_queue #(
  parameter int DEPTH = ipv_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ipv_pkg::ipv_class_t push_item,
  output logic                not_full,
  output logic                head_valid,
  output ipv_pkg::ipv_class_t head_item,
  input  logic                pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  ipv_pkg::ipv_class_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign not_full   = (count != Full);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> (count != Full) || pop)
    else $error("queue pushed while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("queue count beyond depth");

endmodule

[design/ipv_back.sv]
// Back end of the address validator: group tracking and verdict register.
// Depends on ipv_pkg for the class struct and verdict codes.
module ipv_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  ipv_pkg::ipv_class_t head_item,
  output logic                pop,
  output logic [1:0]          verdict,
  output logic                verdict_valid,
  input  logic                verdict_ready
);

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_DOT   = 2'd1,
    MODE_COLON = 2'd2
  } mode_t;

  mode_t      sep_mode;
  logic [3:0] group_count;
  logic [2:0] digit_count;
  logic [8:0] group_value;
  logic       first_is_zero;
  logic       all_decimal;
  logic       all_hex;
  logic       failed;

  mode_t      sep_mode_next;
  logic [3:0] group_count_next;
  logic [2:0] digit_count_next;
  logic [8:0] group_value_next;
  logic       first_is_zero_next;
  logic       all_decimal_next;
  logic       all_hex_next;
  logic       failed_next;
  logic [1:0] verdict_next;

  logic        is_sep;
  logic        closing;
  mode_t       item_mode;
  mode_t       close_mode;
  logic [12:0] scaled;
  logic [2:0]  g_count;
  logic [8:0]  g_value;
  logic        g_zero;
  logic        g_dec;
  logic        g_hex;
  logic        g_ok;
  logic [3:0]  gc_inc;
  logic        load;

  // Take an item unless it is a final one and the verdict slot is still full
  assign pop  = head_valid && (!head_item.last || !verdict_valid || verdict_ready);
  assign load = pop && head_item.last;

  // Update the open group, close it on a separator or the last character
  always_comb begin
    is_sep    = head_item.is_dot | head_item.is_colon;
    closing   = is_sep | head_item.last;
    item_mode = head_item.is_dot ? MODE_DOT : MODE_COLON;
    scaled    = {1'b0, group_value, 3'b000} + {3'b000, group_value, 1'b0}
                + {9'd0, head_item.digit};

    if (is_sep) begin
      g_count    = digit_count;
      g_value    = group_value;
      g_zero     = first_is_zero;
      g_dec      = all_decimal;
      g_hex      = all_hex;
      close_mode = item_mode;
    end else begin
      g_count    = (digit_count == 3'd7) ? 3'd7 : digit_count + 3'd1;
      g_value    = group_value;
      if (head_item.is_dec) begin
        g_value = (scaled > 13'd511) ? 9'd511 : scaled[8:0];
      end
      g_zero     = (digit_count == 3'd0) ? head_item.is_zero : first_is_zero;
      g_dec      = all_decimal & head_item.is_dec;
      g_hex      = all_hex & head_item.is_hex;
      close_mode = sep_mode;
    end

    case (close_mode)
      MODE_DOT: begin
        g_ok = (g_count >= 3'd1) && (g_count <= 3'd3) && g_dec
               && !((g_count > 3'd1) && g_zero) && (g_value <= 9'd255);
      end
      MODE_COLON: begin
        g_ok = (g_count >= 3'd1) && (g_count <= 3'd4) && g_hex;
      end
      default: begin
        g_ok = (g_count >= 3'd1);
      end
    endcase

    gc_inc = (group_count == 4'd15) ? 4'd15 : group_count + 4'd1;

    failed_next = failed;
    if (is_sep) begin
      if (digit_count == 3'd0) failed_next = 1'b1;
      if (sep_mode != MODE_NONE && sep_mode != item_mode) failed_next = 1'b1;
      if (head_item.last) failed_next = 1'b1;
    end
    if (closing) begin
      if (!g_ok) failed_next = 1'b1;
      if (close_mode == MODE_DOT && gc_inc > 4'd4) failed_next = 1'b1;
      if (close_mode == MODE_COLON && gc_inc > 4'd8) failed_next = 1'b1;
    end

    sep_mode_next    = is_sep ? item_mode : sep_mode;
    group_count_next = closing ? gc_inc : group_count;
    if (closing) begin
      digit_count_next   = 3'd0;
      group_value_next   = 9'd0;
      first_is_zero_next = 1'b0;
      all_decimal_next   = 1'b1;
      all_hex_next       = 1'b1;
    end else begin
      digit_count_next   = g_count;
      group_value_next   = g_value;
      first_is_zero_next = g_zero;
      all_decimal_next   = g_dec;
      all_hex_next       = g_hex;
    end

    verdict_next = ipv_pkg::VerdictNeither;
    if (!failed_next) begin
      if (sep_mode_next == MODE_DOT && group_count_next == 4'd4) begin
        verdict_next = ipv_pkg::VerdictIpv4;
      end else if (sep_mode_next == MODE_COLON && group_count_next == 4'd8) begin
        verdict_next = ipv_pkg::VerdictIpv6;
      end
    end
  end

  // Hold string state; clear it after the final character
  always_ff @(posedge clk) begin
    if (rst || load) begin
      sep_mode      <= MODE_NONE;
      group_count   <= 4'd0;
      digit_count   <= 3'd0;
      group_value   <= 9'd0;
      first_is_zero <= 1'b0;
      all_decimal   <= 1'b1;
      all_hex       <= 1'b1;
      failed        <= 1'b0;
    end else if (pop) begin
      sep_mode      <= sep_mode_next;
      group_count   <= group_count_next;
      digit_count   <= digit_count_next;
      group_value   <= group_value_next;
      first_is_zero <= first_is_zero_next;
      all_decimal   <= all_decimal_next;
      all_hex       <= all_hex_next;
      failed        <= failed_next;
    end
  end

  // Hold the verdict until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (load) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict <= verdict_next;
    end
  end

  a_load_slot_free : assert property (@(posedge clk) disable iff (rst)
    load |-> !verdict_valid || verdict_ready)
    else $error("verdict overwritten before it was taken");

  a_clear_after_load : assert property (@(posedge clk) disable iff (rst)
    load |=> sep_mode == MODE_NONE && group_count == 4'd0 && !failed)
    else $error("string state not cleared after final character");

  a_verdict_code : assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> verdict == ipv_pkg::VerdictNeither
      || verdict == ipv_pkg::VerdictIpv4 || verdict == ipv_pkg::VerdictIpv6)
    else $error("verdict holds an unused code");

endmodule

[design/ip_address_text_validator.sv]
// IPv4/IPv6 address text validator, top level.
// With the queue empty, the final character is registered in the queue and then in the verdict register.
// Throughput: one character per cycle while char_ready is high; the back end updates its counters on each pop.
// A full verdict register stalls only final characters; the queue absorbs the rest.
// Reset (rst, synchronous) empties the queue, clears the string state and verdict_valid.
// Depends on ipv_pkg, ipv_front, ipv_queue and ipv_back.
module ip_address_text_validator #(
  parameter int QueueDepth = ipv_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       verdict_valid,
  input  logic       verdict_ready,
  output logic [1:0] verdict
);

  ipv_pkg::ipv_class_t cls;
  ipv_pkg::ipv_class_t head_item;
  logic                head_valid;
  logic                pop;
  logic                not_full;

  // Classify incoming characters
  ipv_front u_front (
    .char_code (char_code),
    .last_char (last_char),
    .cls       (cls)
  );

  assign char_ready = not_full;

  // Decouple front and back
  ipv_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (char_valid && not_full),
    .push_item  (cls),
    .not_full   (not_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  // Track groups and produce the verdict
  ipv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .verdict       (verdict),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready)
  );

endmodule

[tb/ipv_verdict_checker.sv]
// Checker for the address text validator: watches both channels, predicts each verdict
// from the accepted characters and compares it with what the block returns.
// Depends on ipv_pkg for the verdict codes.
module ipv_verdict_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  input  logic       char_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       verdict_valid,
  input  logic       verdict_ready,
  input  logic [1:0] verdict,
  output int         mismatch_count,
  output int         verdicts_pending
);

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  typedef enum logic [1:0] {SepNone, SepDot, SepColon} sep_kind_t;

  // Running state of the string being parsed
  sep_kind_t  sep_kind;
  logic [3:0] groups_closed;
  logic [2:0] group_len;
  logic [8:0] group_val;
  logic       lead_zero;
  logic       only_dec;
  logic       only_hex;
  logic       string_bad;

  logic [1:0] expected_verdicts[$];
  logic [1:0] want;

  task automatic clear_group();
    group_len = '0;
    group_val = '0;
    lead_zero = 1'b0;
    only_dec  = 1'b1;
    only_hex  = 1'b1;
  endtask

  task automatic clear_string();
    sep_kind      = SepNone;
    groups_closed = '0;
    string_bad    = 1'b0;
    clear_group();
  endtask

  function automatic logic group_is_good(sep_kind_t kind);
    case (kind)
      SepDot: begin
        return group_len >= 1 && group_len <= 3 && only_dec &&
               !(group_len > 1 && lead_zero) && group_val <= 255;
      end
      SepColon: begin
        return group_len >= 1 && group_len <= 4 && only_hex;
      end
      default: begin
        return group_len >= 1;
      end
    endcase
  endfunction

  task automatic end_group(sep_kind_t kind);
    if (!group_is_good(kind)) string_bad = 1'b1;
    if (groups_closed != 4'd15) groups_closed = groups_closed + 4'd1;
    if (kind == SepDot && groups_closed > 4) string_bad = 1'b1;
    if (kind == SepColon && groups_closed > 8) string_bad = 1'b1;
    clear_group();
  endtask

  // Advance the parse by one character; queue a verdict on the final one
  task automatic take_char(logic [7:0] c, logic fin);
    sep_kind_t  kind;
    logic       is_dec;
    logic       is_hex;
    int         next_val;
    logic [1:0] result;
    if (c == CharDot || c == CharColon) begin
      kind = (c == CharDot) ? SepDot : SepColon;
      if (group_len == 0) string_bad = 1'b1;
      if (sep_kind != SepNone && sep_kind != kind) string_bad = 1'b1;
      sep_kind = kind;
      end_group(kind);
      if (fin) string_bad = 1'b1;
    end else begin
      is_dec = c >= CharZero && c <= CharNine;
      is_hex = is_dec || (c >= CharLowA && c <= CharLowF) || (c >= CharUpA && c <= CharUpF);
      if (group_len == 0) lead_zero = (c == CharZero);
      if (group_len != 3'd7) group_len = group_len + 3'd1;
      if (!is_dec) only_dec = 1'b0;
      if (!is_hex) only_hex = 1'b0;
      if (is_dec) begin
        next_val  = int'(group_val) * 10 + int'(c - CharZero);
        group_val = (next_val > 511) ? 9'd511 : next_val[8:0];
      end
      if (fin) end_group(sep_kind);
    end
    if (fin) begin
      result = ipv_pkg::VerdictNeither;
      if (!string_bad) begin
        if (sep_kind == SepDot && groups_closed == 4) begin
          result = ipv_pkg::VerdictIpv4;
        end else if (sep_kind == SepColon && groups_closed == 8) begin
          result = ipv_pkg::VerdictIpv6;
        end
      end
      expected_verdicts.push_back(result);
      clear_string();
    end
  endtask

  // Predict on accepted characters, compare accepted verdicts in order
  always @(posedge clk) begin
    if (rst) begin
      clear_string();
      expected_verdicts.delete();
      mismatch_count   <= 0;
      verdicts_pending <= 0;
    end else begin
      if (char_valid && char_ready) take_char(char_code, last_char);
      if (verdict_valid && verdict_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("verdict: expected none, got %0d", verdict);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict !== want) begin
            $error("verdict: expected %0d, got %0d", want, verdict);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      verdicts_pending <= expected_verdicts.size();
    end
  end

endmodule

[tb/testbench.sv]
// Top of the address text validator testbench: clock, reset, character stimulus,
// verdict stalls, watchdog and final verdict.
// Depends on ip_address_text_validator and ipv_verdict_checker.
module testbench;

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam int TextChars  = 1450;
  localparam int StallLimit = 4000;
  localparam int DrainWait  = 10;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       char_valid    = 1'b0;
  logic       char_ready;
  logic [7:0] char_code     = '0;
  logic       last_char     = 1'b0;
  logic       verdict_valid;
  logic       verdict_ready = 1'b0;
  logic [1:0] verdict;

  int mismatch_count;
  int verdicts_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int chars_sent = 0;
  int text_count = 0;
  int quiet_cycles = 0;

  logic [7:0] text_q[$];

  ip_address_text_validator u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_code    (char_code),
    .last_char    (last_char),
    .verdict_valid(verdict_valid),
    .verdict_ready(verdict_ready),
    .verdict      (verdict)
  );

  ipv_verdict_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .char_valid      (char_valid),
    .char_ready      (char_ready),
    .char_code       (char_code),
    .last_char       (last_char),
    .verdict_valid   (verdict_valid),
    .verdict_ready   (verdict_ready),
    .verdict         (verdict),
    .mismatch_count  (mismatch_count),
    .verdicts_pending(verdicts_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the verdict channel at random
  always @(posedge clk) begin
    verdict_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((char_valid && char_ready) || (verdict_valid && verdict_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic set_phase(int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default: begin send_idle_pct = 28; recv_stall_pct = 28; end
    endcase
  endtask

  // Present one character and hold it until accepted
  task automatic send_char(logic [7:0] c, logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= c;
    last_char  <= fin;
    do @(posedge clk); while (!char_ready);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    chars_sent += text_q.size();
    text_count++;
  endtask

  task automatic load_text(string s);
    text_q.delete();
    foreach (s[i]) text_q.push_back(s[i]);
  endtask

  task automatic add_dec(int val);
    string digits_s;
    digits_s = $sformatf("%0d", val);
    foreach (digits_s[i]) text_q.push_back(digits_s[i]);
  endtask

  function automatic logic [7:0] hex_char(int d);
    if (d < 10) return CharZero + 8'(d);
    return ($urandom_range(0, 1) ? CharUpA : CharLowA) + 8'(d - 10);
  endfunction

  task automatic add_hex_group(int ndig);
    repeat (ndig) text_q.push_back(hex_char($urandom_range(0, 15)));
  endtask

  // Four dotted groups, biased toward the value extremes
  task automatic build_v4();
    int val;
    for (int g = 0; g < 4; g++) begin
      if (g > 0) text_q.push_back(CharDot);
      case ($urandom_range(0, 5))
        0: val = 0;
        1: val = 255;
        2: val = $urandom_range(0, 9);
        default: val = $urandom_range(0, 255);
      endcase
      add_dec(val);
    end
  endtask

  task automatic build_v6();
    for (int g = 0; g < 8; g++) begin
      if (g > 0) text_q.push_back(CharColon);
      add_hex_group($urandom_range(1, 4));
    end
  endtask

  // Break a well-formed address in one of several ways
  task automatic corrupt_text(logic dotted);
    logic [7:0] own_sep;
    logic [7:0] other_sep;
    int         pos;
    own_sep   = dotted ? CharDot : CharColon;
    other_sep = dotted ? CharColon : CharDot;
    pos       = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 8))
      0: text_q[pos] = 8'($urandom_range(0, 255));
      1: text_q.delete(pos);
      2: text_q.insert(pos, $urandom_range(0, 1) ? own_sep : other_sep);
      3: text_q.push_back(own_sep);
      4: begin
        repeat ($urandom_range(1, 10)) begin
          text_q.push_back(own_sep);
          if (dotted) add_dec($urandom_range(0, 255));
          else add_hex_group($urandom_range(1, 4));
        end
      end
      5: begin
        while (text_q.size() > 1 && text_q[$] != CharDot && text_q[$] != CharColon)
          void'(text_q.pop_back());
        if (text_q.size() > 1) void'(text_q.pop_back());
      end
      6: text_q[pos] = other_sep;
      7: begin
        repeat ($urandom_range(1, 8))
          text_q.insert(pos, dotted ? CharZero + 8'($urandom_range(0, 9))
                                    : hex_char($urandom_range(0, 15)));
      end
      default: text_q.insert(0, CharZero);
    endcase
  endtask

  // Random bytes with separators and digits mixed in
  task automatic build_noise();
    int r;
    repeat ($urandom_range(1, 24)) begin
      r = $urandom_range(0, 9);
      if (r < 2) text_q.push_back($urandom_range(0, 1) ? CharDot : CharColon);
      else if (r < 6) text_q.push_back(hex_char($urandom_range(0, 15)));
      else text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic make_random_text();
    int   kind;
    logic dotted;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      build_v4();
    end else if (kind < 60) begin
      build_v6();
    end else if (kind < 85) begin
      dotted = 1'($urandom_range(0, 1));
      if (dotted) build_v4();
      else build_v6();
      corrupt_text(dotted);
    end else begin
      build_noise();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: zero groups, lone and trailing separators, no separator,
    // mixed separators, extreme byte codes
    set_phase(0);
    load_text("0.0.0.0"); send_text();
    load_text(":");       send_text();
    load_text("1.");      send_text();
    load_text("x");       send_text();
    load_text("1:.");     send_text();
    text_q = '{8'h00};    send_text();
    text_q = '{8'hFF};    send_text();

    // Random strings, rotating through the idle and stall mixes
    while (chars_sent < TextChars) begin
      set_phase((text_count / 6) % 4);
      make_random_text();
      send_text();
    end
    char_valid <= 1'b0;

    // Drain the outstanding verdicts, then give the block time for strays
    do @(posedge clk); while (verdicts_pending != 0);
    repeat (DrainWait) @(posedge clk);

    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
design/ipv_pkg.sv
design/ipv_front.sv
design/ipv_queue.sv
design/ipv_back.sv
design/ip_address_text_validator.sv
tb/ipv_verdict_checker.sv
tb/testbench.sv
